/* design/ilp_pkg.sv */
// Shared types and character constants for the integer literal parser.
`default_nettype none

package ilp_pkg;

    typedef enum logic [1:0] {
        CP_START  = 2'd0,
        CP_MINUS  = 2'd1,
        CP_PLUS   = 2'd2,
        CP_DIGITS = 2'd3
    } t_char_pos;

    typedef enum logic [1:0] {
        PF_NONE = 2'd0,
        PF_ZERO = 2'd1,
        PF_X    = 2'd2
    } t_prefix;

    typedef enum logic [2:0] {
        ERR_NONE           = 3'd0,
        ERR_MINUS_UNSIGNED = 3'd1,
        ERR_NO_DIGIT       = 3'd2,
        ERR_OVERFLOW       = 3'd3,
        ERR_BAD_BIN        = 3'd4,
        ERR_NO_HEX         = 3'd5,
        ERR_BAD_HEX        = 3'd6,
        ERR_BAD_DEC        = 3'd7
    } t_err;

    typedef struct packed {
        logic [15:0] char_code;
        logic        last_char;
    } t_item;

    typedef struct packed {
        t_err err;
        logic neg;
    } t_result;

    localparam int unsigned VALUE_W = 64;

    localparam logic [15:0] CH_0     = 16'h0030;
    localparam logic [15:0] CH_1     = 16'h0031;
    localparam logic [15:0] CH_9     = 16'h0039;
    localparam logic [15:0] CH_UP_A  = 16'h0041;
    localparam logic [15:0] CH_UP_B  = 16'h0042;
    localparam logic [15:0] CH_UP_F  = 16'h0046;
    localparam logic [15:0] CH_UP_X  = 16'h0058;
    localparam logic [15:0] CH_LO_A  = 16'h0061;
    localparam logic [15:0] CH_LO_B  = 16'h0062;
    localparam logic [15:0] CH_LO_F  = 16'h0066;
    localparam logic [15:0] CH_LO_X  = 16'h0078;
    localparam logic [15:0] CH_PLUS  = 16'h002B;
    localparam logic [15:0] CH_MINUS = 16'h002D;

endpackage

`default_nettype wire

/* design/integer_literal_parser_top.sv */
// A last character passes the input register, then the result register.
// Throughput: one character per cycle; the input register, the parse step and
// the result register overlap. A last character waits only while the result
// register still holds an untaken result.
// Reset: synchronous active-low i_rst_n clears the literal state, the
// signed_mode register and both valid flags.
`default_nettype none

module integer_literal_parser_top
    import ilp_pkg::*;
#(
    parameter int unsigned ACC_WIDTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_wr_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [15:0]        i_char_code,
    input  wire logic               i_last_char,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [VALUE_W-1:0]      o_value,
    output logic [2:0]              o_error_code
);

    logic                 r_signed_mode;
    logic                 item_valid;
    t_item                item;
    logic                 out_free;
    logic                 fire;
    logic                 res_valid;
    t_result              res;
    logic [ACC_WIDTH-1:0] mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_signed_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_signed_mode <= i_cfg_wr_data;
        end
    end

    // hold a last character only while the result slot is occupied
    assign out_free = !o_out_valid || !i_out_stall;
    assign fire     = item_valid && (!item.last_char || out_free);

    ilp_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_char_code (i_char_code),
        .i_last_char (i_last_char),
        .i_take      (fire),
        .o_in_stall  (o_in_stall),
        .o_valid     (item_valid),
        .o_item      (item)
    );

    ilp_core #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (fire),
        .i_item        (item),
        .i_signed_mode (r_signed_mode),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_mag         (mag)
    );

    ilp_out_reg #(
        .ACC_WIDTH (ACC_WIDTH)
    ) u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (res_valid),
        .i_res        (res),
        .i_mag        (mag),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_value      (o_value),
        .o_error_code (o_error_code)
    );

endmodule

`default_nettype wire

/* design/ilp_in_reg.sv */
// Input register stage: holds one character transfer until the parser takes it.
`default_nettype none

module ilp_in_reg
    import ilp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic [15:0] i_char_code,
    input  wire logic        i_last_char,
    input  wire logic        i_take,
    output logic             o_in_stall,
    output logic             o_valid,
    output t_item            o_item
);

    logic  r_valid;
    t_item r_item;
    logic  load;

    assign o_in_stall = r_valid && !i_take;
    assign load       = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.char_code <= i_char_code;
            r_item.last_char <= i_last_char;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

/* design/ilp_core.sv */
// Per-character parse step: literal state, decimal/hex and binary accumulators.
`default_nettype none

module ilp_core
    import ilp_pkg::*;
#(
    parameter int unsigned ACC_WIDTH = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_fire,
    input  wire t_item                i_item,
    input  wire logic                 i_signed_mode,
    output logic                      o_res_valid,
    output t_result                   o_res,
    output logic [ACC_WIDTH-1:0]      o_mag
);

    localparam int unsigned XW = ACC_WIDTH + 4;

    t_char_pos              r_char_pos, n_char_pos;
    t_prefix                r_prefix, n_prefix;
    logic                   r_neg, n_neg;
    logic                   r_hex, n_hex;
    logic [ACC_WIDTH-1:0]   r_dec_acc, n_dec_acc;
    logic [ACC_WIDTH-1:0]   r_bin_acc, n_bin_acc;
    logic                   r_bin_stop, n_bin_stop;
    t_err                   r_bin_err, n_bin_err;
    t_err                   r_main_err, n_main_err;

    logic [15:0]            c;
    logic                   is_dec, is_hex, is_bit, is_b, is_x;
    logic [3:0]             hex_val;
    logic [ACC_WIDTH-1:0]   lim;
    logic [ACC_WIDTH-1:0]   min_mag;
    logic [XW-1:0]          dec_sum, hex_sum, main_sum;
    logic                   main_ovf;
    logic [ACC_WIDTH:0]     bin_sum;
    logic                   bin_ovf;

    logic                   body;
    t_prefix                prefix_in;
    t_err                   fin_err;
    logic [ACC_WIDTH-1:0]   fin_mag;

    assign c       = i_item.char_code;
    assign is_dec  = c inside {[CH_0:CH_9]};
    assign is_hex  = is_dec || (c inside {[CH_UP_A:CH_UP_F]}) || (c inside {[CH_LO_A:CH_LO_F]});
    assign is_bit  = (c == CH_0) || (c == CH_1);
    assign is_b    = (c == CH_UP_B) || (c == CH_LO_B);
    assign is_x    = (c == CH_UP_X) || (c == CH_LO_X);
    // letters a-f / A-F sit one above a multiple of 16, so low nibble + 9
    assign hex_val = is_dec ? c[3:0] : c[3:0] + 4'd9;

    assign min_mag = {1'b1, {(ACC_WIDTH-1){1'b0}}};
    assign lim     = i_signed_mode ? min_mag : {ACC_WIDTH{1'b1}};

    // acc * base + digit, checked against the limit in a wider word
    assign dec_sum  = (XW'(r_dec_acc) << 3) + (XW'(r_dec_acc) << 1) + XW'(c[3:0]);
    assign hex_sum  = (XW'(r_dec_acc) << 4) + XW'(hex_val);
    assign main_sum = r_hex ? hex_sum : dec_sum;
    assign main_ovf = main_sum > XW'(lim);
    assign bin_sum  = {r_bin_acc, c[0]};
    assign bin_ovf  = bin_sum > {1'b0, lim};

    always_comb begin
        n_char_pos = r_char_pos;
        n_prefix   = r_prefix;
        n_neg      = r_neg;
        n_hex      = r_hex;
        n_dec_acc  = r_dec_acc;
        n_bin_acc  = r_bin_acc;
        n_bin_stop = r_bin_stop;
        n_bin_err  = r_bin_err;
        n_main_err = r_main_err;
        body       = 1'b0;
        prefix_in  = r_prefix;

        if (r_char_pos != CP_DIGITS) begin
            if (is_dec) begin
                n_char_pos = CP_DIGITS;
                prefix_in  = PF_NONE;
                body       = 1'b1;
            end else if (r_char_pos == CP_START && c == CH_MINUS) begin
                if (i_signed_mode) begin
                    n_neg      = 1'b1;
                    n_char_pos = CP_MINUS;
                end else begin
                    n_main_err = ERR_MINUS_UNSIGNED;
                    n_bin_err  = ERR_MINUS_UNSIGNED;
                    n_char_pos = CP_DIGITS;
                end
            end else if (r_char_pos != CP_PLUS && c == CH_PLUS) begin
                n_char_pos = CP_PLUS;
            end else begin
                n_main_err = ERR_NO_DIGIT;
                n_bin_err  = ERR_NO_DIGIT;
                n_char_pos = CP_DIGITS;
            end
        end else begin
            body = 1'b1;
        end

        if (body) begin
            // binary reading runs alongside until the first non-bit character or its first error
            if (!r_bin_stop && r_bin_err == ERR_NONE) begin
                if (is_bit) begin
                    if (bin_ovf) begin
                        n_bin_err = ERR_OVERFLOW;
                    end else begin
                        n_bin_acc = bin_sum[ACC_WIDTH-1:0];
                    end
                end else begin
                    n_bin_stop = 1'b1;
                    if (!is_b) begin
                        n_bin_err = ERR_BAD_BIN;
                    end
                end
            end

            if (prefix_in == PF_ZERO && is_x) begin
                n_hex    = 1'b1;
                n_prefix = PF_X;
            end else begin
                n_prefix = PF_NONE;
                if (r_main_err == ERR_NONE) begin
                    if (r_hex ? !is_hex : !is_dec) begin
                        n_main_err = r_hex ? ERR_BAD_HEX : ERR_BAD_DEC;
                    end else if (main_ovf) begin
                        n_main_err = ERR_OVERFLOW;
                    end else begin
                        n_dec_acc = main_sum[ACC_WIDTH-1:0];
                    end
                end
            end

            if (r_char_pos != CP_DIGITS && c == CH_0) begin
                n_prefix = PF_ZERO;
            end
        end
    end

    // pick the reading and final error at the last character
    always_comb begin
        fin_err = ERR_NONE;
        fin_mag = '0;
        if (n_char_pos != CP_DIGITS) begin
            fin_err = ERR_NO_DIGIT;
        end else if (n_hex) begin
            fin_err = n_main_err;
            if (fin_err == ERR_NONE && n_prefix == PF_X) begin
                fin_err = ERR_NO_HEX;
            end
            fin_mag = n_dec_acc;
        end else if (is_b) begin
            fin_err = n_bin_err;
            fin_mag = n_bin_acc;
        end else begin
            fin_err = n_main_err;
            fin_mag = n_dec_acc;
        end
        if (fin_err == ERR_NONE && !n_neg && i_signed_mode && fin_mag == min_mag) begin
            fin_err = ERR_OVERFLOW;
        end
    end

    assign o_res_valid = i_fire && i_item.last_char;
    assign o_res.err   = fin_err;
    assign o_res.neg   = n_neg;
    assign o_mag       = fin_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last_char)) begin
            r_char_pos <= CP_START;
            r_prefix   <= PF_NONE;
            r_neg      <= 1'b0;
            r_hex      <= 1'b0;
            r_dec_acc  <= '0;
            r_bin_acc  <= '0;
            r_bin_stop <= 1'b0;
            r_bin_err  <= ERR_NONE;
            r_main_err <= ERR_NONE;
        end else if (i_fire) begin
            r_char_pos <= n_char_pos;
            r_prefix   <= n_prefix;
            r_neg      <= n_neg;
            r_hex      <= n_hex;
            r_dec_acc  <= n_dec_acc;
            r_bin_acc  <= n_bin_acc;
            r_bin_stop <= n_bin_stop;
            r_bin_err  <= n_bin_err;
            r_main_err <= n_main_err;
        end
    end

endmodule

`default_nettype wire

/* design/ilp_out_reg.sv */
// Result register: holds one finished literal and applies the sign on the way out.
`default_nettype none

module ilp_out_reg
    import ilp_pkg::*;
#(
    parameter int unsigned ACC_WIDTH = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire t_result              i_res,
    input  wire logic [ACC_WIDTH-1:0] i_mag,
    input  wire logic                 i_out_stall,
    output logic                      o_out_valid,
    output logic [VALUE_W-1:0]        o_value,
    output logic [2:0]                o_error_code
);

    logic                 r_valid;
    t_result              r_res;
    logic [ACC_WIDTH-1:0] r_mag;
    logic [ACC_WIDTH-1:0] signed_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
            r_mag <= i_mag;
        end
    end

    // zero on error, two's complement when negative
    assign signed_val   = (r_res.err != ERR_NONE) ? '0 :
                          r_res.neg ? ('0 - r_mag) : r_mag;
    assign o_out_valid  = r_valid;
    assign o_value      = VALUE_W'(signed_val);
    assign o_error_code = r_res.err;

endmodule

`default_nettype wire
